FILE: hw/rtl/aft_pkg.sv
// ----------------------------------------------------------------------------
// Affine fit package
// Widths, payload item types and fixed-point constants shared by the affine
// fit solver and its division pipeline.
// ----------------------------------------------------------------------------
package aft_pkg;

  // Coordinate and coefficient formats.
  localparam int CoordW     = 24;
  localparam int CoefW      = 32;
  localparam int CoefFrac   = 16;
  localparam int TransShift = 8;

  // Degeneracy threshold register, reset to 0.001 in units of 2^-16.
  localparam int              ThrW     = 32;
  localparam logic [ThrW-1:0] ThrReset = ThrW'(66);

  // Width of the determinant and of the linear numerators (sum of three products).
  localparam int SumW     = 2 * CoordW + 3;
  // Width of the translation numerators.
  localparam int TrW      = 3 * CoordW + 3;
  // Dividend widths: 2 * (|num| << shift) + |det|.
  localparam int NumLinW  = SumW + CoefFrac + 2;
  localparam int NumTrW   = TrW + TransShift + 2;
  // Divisor width: 2 * |det|.
  localparam int DivW     = SumW + 1;

  typedef struct packed {
    logic signed [CoordW-1:0] src_x0;
    logic signed [CoordW-1:0] src_y0;
    logic signed [CoordW-1:0] dst_x0;
    logic signed [CoordW-1:0] dst_y0;
    logic signed [CoordW-1:0] src_x1;
    logic signed [CoordW-1:0] src_y1;
    logic signed [CoordW-1:0] dst_x1;
    logic signed [CoordW-1:0] dst_y1;
    logic signed [CoordW-1:0] src_x2;
    logic signed [CoordW-1:0] src_y2;
    logic signed [CoordW-1:0] dst_x2;
    logic signed [CoordW-1:0] dst_y2;
  } aft_in_t;

  typedef struct packed {
    logic signed [CoefW-1:0] coef_p;
    logic signed [CoefW-1:0] coef_q;
    logic signed [CoefW-1:0] coef_a;
    logic signed [CoefW-1:0] coef_r;
    logic signed [CoefW-1:0] coef_s;
    logic signed [CoefW-1:0] coef_b;
    logic                    fit_valid;
  } aft_out_t;

endpackage

FILE: hw/rtl/aft_div.sv
// ----------------------------------------------------------------------------
// Affine fit divider
// Pipelined restoring division of an unsigned dividend by an unsigned divisor,
// one quotient bit per stage, with an overflow flag when the quotient does not
// fit in QW bits.
// ----------------------------------------------------------------------------
module aft_div
  import aft_pkg::*;
#(
  parameter int NW = NumLinW,
  parameter int DW = DivW,
  parameter int QW = CoefW
) (
  input  logic          clk,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  output logic          ovf_o,
  output logic [QW-1:0] q_o
);

  localparam int NH   = NW - QW;
  localparam int CMPW = ((NH > DW) ? NH : DW) + 1;

  logic [DW-1:0] r_r   [QW+1];
  logic [DW-1:0] d_r   [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic [QW-1:0] nlo_r [QW+1];
  logic          ovf_r [QW+1];

  logic [NH-1:0] n_hi;

  assign n_hi = n_i[NW-1:QW];

  // Entry stage: the quotient overflows when the upper dividend bits reach the divisor.
  always_ff @(posedge clk) begin
    ovf_r[0] <= (CMPW'(n_hi) >= CMPW'(d_i));
    r_r[0]   <= DW'(n_hi);
    d_r[0]   <= d_i;
    q_r[0]   <= '0;
    nlo_r[0] <= n_i[QW-1:0];
  end

  // One quotient bit per stage: shift in the next dividend bit, then trial subtract.
  for (genvar i = 1; i <= QW; i++) begin : g_stage
    logic [DW:0] rem_sh;
    logic [DW:0] diff;

    assign rem_sh = {r_r[i-1], nlo_r[i-1][QW-1]};
    assign diff   = rem_sh - {1'b0, d_r[i-1]};

    always_ff @(posedge clk) begin
      if (!diff[DW]) begin
        r_r[i] <= diff[DW-1:0];
      end else begin
        r_r[i] <= rem_sh[DW-1:0];
      end
      q_r[i]   <= {q_r[i-1][QW-2:0], ~diff[DW]};
      nlo_r[i] <= {nlo_r[i-1][QW-2:0], 1'b0};
      d_r[i]   <= d_r[i-1];
      ovf_r[i] <= ovf_r[i-1];
    end
  end

  assign q_o   = q_r[QW];
  assign ovf_o = ovf_r[QW];

endmodule

FILE: hw/rtl/affine_fit_three_pairs.sv
// ----------------------------------------------------------------------------
// Affine fit from three point pairs
// Closed-form solver for the affine map taking three source points onto three
// target points, using the adjugate of the source matrix over its determinant.
// ----------------------------------------------------------------------------
// The block takes one item in every cycle and never raises busy. Each result
// appears on out_data for a single cycle with out_strobe high, once its item has
// passed the front stages and the division pipeline, which resolves one quotient
// bit per stage for all six coefficients in parallel. Results cannot be held off,
// so the receiver must take every strobe. The threshold register may be
// written at any time through the cfg port, which is always ready, but should
// only change while no item is in flight.
module affine_fit_three_pairs
  import aft_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  aft_in_t         in_data,
  output logic            out_strobe,
  output aft_out_t        out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [ThrW-1:0] cfg_data
);

  localparam int W    = CoordW;
  localparam int DFW  = W + 1;          // coordinate differences
  localparam int PW   = 2 * W;          // coordinate products
  localparam int EW   = 2 * W + 1;      // translation cofactors
  localparam int LPW  = 2 * W + 1;      // difference times coordinate
  localparam int H    = W + 1;          // split point of the cofactors
  localparam int LOW  = 2 * W + 2;      // low cofactor part times coordinate
  localparam int HIW  = 2 * W;          // high cofactor part times coordinate
  localparam int DLAT = CoefW + 1;      // divider register stages

  typedef struct packed {
    logic       fit;
    logic [5:0] neg;
  } flag_t;

  // Configuration register.
  logic [ThrW-1:0] thr_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ThrReset;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  // Unpack the item into per-point arrays.
  logic signed [W-1:0] xi [3];
  logic signed [W-1:0] yi [3];
  logic signed [W-1:0] ui [3];
  logic signed [W-1:0] vi [3];

  assign xi[0] = in_data.src_x0;
  assign xi[1] = in_data.src_x1;
  assign xi[2] = in_data.src_x2;
  assign yi[0] = in_data.src_y0;
  assign yi[1] = in_data.src_y1;
  assign yi[2] = in_data.src_y2;
  assign ui[0] = in_data.dst_x0;
  assign ui[1] = in_data.dst_x1;
  assign ui[2] = in_data.dst_x2;
  assign vi[0] = in_data.dst_y0;
  assign vi[1] = in_data.dst_y1;
  assign vi[2] = in_data.dst_y2;

  // Valid bits of the front stages.
  logic [6:1] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:1], start && !busy};
    end
  end

  // Stage 1 to 3 registers.
  logic signed [W-1:0]   x1_r  [3];
  logic signed [W-1:0]   u1_r  [3];
  logic signed [W-1:0]   v1_r  [3];
  logic signed [DFW-1:0] c1_r  [3];
  logic signed [DFW-1:0] d1_r  [3];
  logic signed [PW-1:0]  pa1_r [3];
  logic signed [PW-1:0]  pb1_r [3];

  logic signed [W-1:0]   u2_r  [3];
  logic signed [W-1:0]   v2_r  [3];
  logic signed [EW-1:0]  e2_r  [3];
  logic signed [LPW-1:0] dp2_r [3];
  logic signed [LPW-1:0] cu2_r [3];
  logic signed [LPW-1:0] cv2_r [3];
  logic signed [LPW-1:0] du2_r [3];
  logic signed [LPW-1:0] dv2_r [3];

  logic signed [LOW-1:0] lou3_r [3];
  logic signed [LOW-1:0] lov3_r [3];
  logic signed [HIW-1:0] hiu3_r [3];
  logic signed [HIW-1:0] hiv3_r [3];

  for (genvar k = 0; k < 3; k++) begin : g_point
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;

    logic [H-1:0]          e_lo;
    logic signed [W-1:0]   e_hi;

    assign e_lo = e2_r[k][H-1:0];
    assign e_hi = e2_r[k][EW-1:H];

    always_ff @(posedge clk) begin
      // Stage 1: row differences and cross products of the source points.
      x1_r[k]  <= xi[k];
      u1_r[k]  <= ui[k];
      v1_r[k]  <= vi[k];
      c1_r[k]  <= DFW'(yi[K1]) - DFW'(yi[K2]);
      d1_r[k]  <= DFW'(xi[K2]) - DFW'(xi[K1]);
      pa1_r[k] <= xi[K1] * yi[K2];
      pb1_r[k] <= xi[K2] * yi[K1];
      // Stage 2: cofactors and the products feeding the linear terms.
      u2_r[k]  <= u1_r[k];
      v2_r[k]  <= v1_r[k];
      e2_r[k]  <= EW'(pa1_r[k]) - EW'(pb1_r[k]);
      dp2_r[k] <= x1_r[k] * c1_r[k];
      cu2_r[k] <= c1_r[k] * u1_r[k];
      cv2_r[k] <= c1_r[k] * v1_r[k];
      du2_r[k] <= d1_r[k] * u1_r[k];
      dv2_r[k] <= d1_r[k] * v1_r[k];
      // Stage 3: the wide cofactors are multiplied in two halves.
      lou3_r[k] <= $signed({1'b0, e_lo}) * u2_r[k];
      lov3_r[k] <= $signed({1'b0, e_lo}) * v2_r[k];
      hiu3_r[k] <= e_hi * u2_r[k];
      hiv3_r[k] <= e_hi * v2_r[k];
    end
  end

  // Stage 3: determinant and linear numerators (p, q, r, s order).
  logic signed [SumW-1:0] det3_r;
  logic signed [SumW-1:0] nl3_r [4];

  always_ff @(posedge clk) begin
    det3_r   <= SumW'(dp2_r[0]) + SumW'(dp2_r[1]) + SumW'(dp2_r[2]);
    nl3_r[0] <= SumW'(cu2_r[0]) + SumW'(cu2_r[1]) + SumW'(cu2_r[2]);
    nl3_r[1] <= SumW'(du2_r[0]) + SumW'(du2_r[1]) + SumW'(du2_r[2]);
    nl3_r[2] <= SumW'(cv2_r[0]) + SumW'(cv2_r[1]) + SumW'(cv2_r[2]);
    nl3_r[3] <= SumW'(dv2_r[0]) + SumW'(dv2_r[1]) + SumW'(dv2_r[2]);
  end

  // Stage 4: translation numerators, determinant magnitude and the fit test.
  logic signed [SumW-1:0] nl4_r [4];
  logic signed [TrW-1:0]  nt4_r [2];
  logic [SumW-1:0]        md4_r;
  logic                   dneg4_r;
  logic                   fit4_r;
  logic [SumW-1:0]        md_nxt;

  assign md_nxt = det3_r[SumW-1] ? (~det3_r + SumW'(1)) : det3_r;

  always_ff @(posedge clk) begin
    nl4_r   <= nl3_r;
    nt4_r[0] <= (TrW'(hiu3_r[0]) <<< H) + TrW'(lou3_r[0])
              + (TrW'(hiu3_r[1]) <<< H) + TrW'(lou3_r[1])
              + (TrW'(hiu3_r[2]) <<< H) + TrW'(lou3_r[2]);
    nt4_r[1] <= (TrW'(hiv3_r[0]) <<< H) + TrW'(lov3_r[0])
              + (TrW'(hiv3_r[1]) <<< H) + TrW'(lov3_r[1])
              + (TrW'(hiv3_r[2]) <<< H) + TrW'(lov3_r[2]);
    md4_r   <= md_nxt;
    dneg4_r <= det3_r[SumW-1];
    fit4_r  <= (md_nxt > SumW'(thr_r));
  end

  // Stage 5: numerator magnitudes and result signs (p, q, a, r, s, b order).
  logic [SumW-1:0] ml5_r [4];
  logic [TrW-1:0]  mt5_r [2];
  logic [SumW-1:0] md5_r;
  logic [5:0]      neg5_r;
  logic            fit5_r;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      ml5_r[j] <= nl4_r[j][SumW-1] ? (~nl4_r[j] + SumW'(1)) : nl4_r[j];
    end
    for (int j = 0; j < 2; j++) begin
      mt5_r[j] <= nt4_r[j][TrW-1] ? (~nt4_r[j] + TrW'(1)) : nt4_r[j];
    end
    neg5_r <= {nt4_r[1][TrW-1], nl4_r[3][SumW-1], nl4_r[2][SumW-1],
               nt4_r[0][TrW-1], nl4_r[1][SumW-1], nl4_r[0][SumW-1]}
              ^ {6{dneg4_r}};
    md5_r  <= md4_r;
    fit5_r <= fit4_r;
  end

  // Stage 6: rounded dividends 2 * (|num| << shift) + |det| and divisor 2 * |det|.
  logic [NumLinW-1:0] nl6_r [4];
  logic [NumTrW-1:0]  nt6_r [2];
  logic [DivW-1:0]    dv6_r;
  flag_t              flag6_r;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      nl6_r[j] <= (NumLinW'(ml5_r[j]) << (CoefFrac + 1)) + NumLinW'(md5_r);
    end
    for (int j = 0; j < 2; j++) begin
      nt6_r[j] <= (NumTrW'(mt5_r[j]) << (TransShift + 1)) + NumTrW'(md5_r);
    end
    dv6_r       <= {md5_r, 1'b0};
    flag6_r.fit <= fit5_r;
    flag6_r.neg <= neg5_r;
  end

  // Six division pipelines, one per coefficient.
  logic [CoefW-1:0] q_div   [6];
  logic             ovf_div [6];

  for (genvar j = 0; j < 4; j++) begin : g_lin
    localparam int SLOT = (j < 2) ? j : j + 1;

    aft_div #(
      .NW (NumLinW),
      .DW (DivW),
      .QW (CoefW)
    ) u_div (
      .clk   (clk),
      .n_i   (nl6_r[j]),
      .d_i   (dv6_r),
      .ovf_o (ovf_div[SLOT]),
      .q_o   (q_div[SLOT])
    );
  end

  for (genvar j = 0; j < 2; j++) begin : g_trans
    localparam int SLOT = 3 * j + 2;

    aft_div #(
      .NW (NumTrW),
      .DW (DivW),
      .QW (CoefW)
    ) u_div (
      .clk   (clk),
      .n_i   (nt6_r[j]),
      .d_i   (dv6_r),
      .ovf_o (ovf_div[SLOT]),
      .q_o   (q_div[SLOT])
    );
  end

  // Valid bits and flags travel alongside the division pipelines.
  logic [DLAT-1:0] fvld_r;
  flag_t           flag_r [DLAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvld_r <= '0;
    end else begin
      fvld_r <= {fvld_r[DLAT-2:0], vld_r[6]};
    end
  end

  always_ff @(posedge clk) begin
    flag_r[0] <= flag6_r;
    for (int i = 1; i < DLAT; i++) begin
      flag_r[i] <= flag_r[i-1];
    end
  end

  // Apply the sign and saturate to the coefficient range.
  function automatic logic [CoefW-1:0] sat_coef(input logic [CoefW-1:0] q,
                                                 input logic ovf, input logic neg);
    logic [CoefW-1:0] res;
    if (neg) begin
      if (ovf || (q[CoefW-1] && (|q[CoefW-2:0]))) begin
        res = {1'b1, {(CoefW-1){1'b0}}};
      end else begin
        res = ~q + CoefW'(1);
      end
    end else begin
      if (ovf || q[CoefW-1]) begin
        res = {1'b0, {(CoefW-1){1'b1}}};
      end else begin
        res = q;
      end
    end
    return res;
  endfunction

  logic [CoefW-1:0] coef_nxt [6];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      coef_nxt[j] = flag_r[DLAT-1].fit ?
                    sat_coef(q_div[j], ovf_div[j], flag_r[DLAT-1].neg[j]) : '0;
    end
  end

  // Output register: one cycle strobe per item.
  aft_out_t out_data_r;
  logic     out_strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= fvld_r[DLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.coef_p    <= coef_nxt[0];
    out_data_r.coef_q    <= coef_nxt[1];
    out_data_r.coef_a    <= coef_nxt[2];
    out_data_r.coef_r    <= coef_nxt[3];
    out_data_r.coef_s    <= coef_nxt[4];
    out_data_r.coef_b    <= coef_nxt[5];
    out_data_r.fit_valid <= flag_r[DLAT-1].fit;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // A degenerate fit reports all coefficients as zero.
  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.fit_valid) |->
      (out_data.coef_p == '0 && out_data.coef_q == '0 && out_data.coef_a == '0 &&
       out_data.coef_r == '0 && out_data.coef_s == '0 && out_data.coef_b == '0))
    else $error("degenerate fit with nonzero coefficients");

  // Reset flushes the pipeline, so no result follows a reset cycle.
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe straight after reset");

  // A valid fit whose p coefficient is positive never reports a negative coef_p.
  a_sign_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (fvld_r[DLAT-1] && flag_r[DLAT-1].fit && !flag_r[DLAT-1].neg[0]) |=>
      !out_data.coef_p[CoefW-1])
    else $error("positive coefficient came out negative");

endmodule
